[rtl/fvpi_pkg.sv]
// Shared types, constants and microcode table for the flow velocity PI controller.
`timescale 1ns / 1ps
`default_nettype none

package fvpi_pkg;

  // Controller constants
  localparam int ALPHA_Q8  = 26;
  localparam int SAT_LIMIT = 1500;
  localparam int DIV_DEN   = 100;
  localparam int NORM_ONE  = 1 << 24;

  // Field widths
  localparam int VEL_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int CNT_W    = 10;
  localparam int CMD_W    = 16;
  localparam int ERR_W    = 18;
  localparam int SUM_W    = 32;
  localparam int METHOD_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int PC_W     = 5;

  // Shared multiplier and accumulator
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 50;

  // Divide by DIV_DEN through a reciprocal: valid for magnitudes below 2^DIV_N_W
  localparam int DIV_N_W   = 22;
  localparam int DIV_SHIFT = DIV_N_W + 7;
  localparam int DIV_M     = ((1 << DIV_SHIFT) + DIV_DEN - 1) / DIV_DEN;
  localparam int LIMIT_P   = (SAT_LIMIT + 1) * DIV_DEN;

  // Method codes
  localparam logic [METHOD_W-1:0] METHOD_PASS  = 3'd0;
  localparam logic [METHOD_W-1:0] METHOD_AVOID = 3'd2;
  localparam logic [METHOD_W-1:0] METHOD_HOVER = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_P_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_I_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_P_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_I_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VY    = 3'd6;

  typedef struct packed {
    logic                    restart;
    logic                    mode_active;
    logic [CNT_W-1:0]        tracked_count;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] avoid_roll;
    logic signed [VEL_W-1:0] avoid_pitch;
  } in_item_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] roll_cmd;
    logic signed [CMD_W-1:0] pitch_cmd;
  } out_item_t;

  typedef struct packed {
    logic [METHOD_W-1:0]     method;
    logic [GAIN_W-1:0]       roll_p_gain;
    logic [GAIN_W-1:0]       roll_i_gain;
    logic [GAIN_W-1:0]       pitch_p_gain;
    logic [GAIN_W-1:0]       pitch_i_gain;
    logic signed [VEL_W-1:0] target_vx;
    logic signed [VEL_W-1:0] target_vy;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    method:       METHOD_HOVER,
    roll_p_gain:  16'd400,
    roll_i_gain:  16'd20,
    pitch_p_gain: 16'd400,
    pitch_i_gain: 16'd20,
    target_vx:    16'sd0,
    target_vy:    16'sd0
  };

  // Microcode fields
  typedef enum logic [2:0] {
    MUL_NONE, MUL_SQ_ROLL, MUL_SQ_PITCH, MUL_P_ERR, MUL_I_SUM, MUL_RECIP
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ABS
  } acc_op_t;

  typedef enum logic [2:0] {
    DP_NOP, DP_CLEAR, DP_PASS, DP_ERR, DP_SUM, DP_CMD
  } dp_op_t;

  typedef enum logic {
    JMP_NONE, JMP_AXIS
  } jmp_t;

  typedef struct packed {
    mul_sel_t        mul_sel;
    acc_op_t         acc_op;
    dp_op_t          dp_op;
    jmp_t            jmp;
    logic            last;
    logic [PC_W-1:0] jmp_addr;
  } uword_t;

  // Control handed from sequencer to datapath
  typedef struct packed {
    logic     en;
    logic     axis;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    dp_op_t   dp_op;
  } ctl_t;

  // Program entry points
  localparam logic [PC_W-1:0] PC_RESTART = 5'd0;
  localparam logic [PC_W-1:0] PC_HOLD    = 5'd1;
  localparam logic [PC_W-1:0] PC_PASS    = 5'd2;
  localparam logic [PC_W-1:0] PC_AVOID   = 5'd3;
  localparam logic [PC_W-1:0] PC_HOVER   = 5'd6;
  localparam logic [PC_W-1:0] PC_AXIS    = 5'd8;

  // Control store: one word per step
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    unique case (pc)
      PC_RESTART: begin
        w.dp_op = DP_CLEAR;
        w.last  = 1'b1;
      end
      PC_HOLD: begin
        w.last = 1'b1;
      end
      PC_PASS: begin
        w.dp_op = DP_PASS;
        w.last  = 1'b1;
      end
      // squared norm of avoidance vector
      PC_AVOID: begin
        w.mul_sel = MUL_SQ_ROLL;
      end
      5'd4: begin
        w.mul_sel = MUL_SQ_PITCH;
        w.acc_op  = ACC_LOAD;
      end
      5'd5: begin
        w.acc_op = ACC_ADD;
      end
      // errors and sums
      PC_HOVER: begin
        w.dp_op = DP_ERR;
      end
      5'd7: begin
        w.dp_op = DP_SUM;
      end
      // per-axis PI, run once for x and once for y
      PC_AXIS: begin
        w.mul_sel = MUL_P_ERR;
      end
      5'd9: begin
        w.mul_sel = MUL_I_SUM;
        w.acc_op  = ACC_LOAD;
      end
      5'd10: begin
        w.acc_op = ACC_ADD;
      end
      5'd11: begin
        w.acc_op = ACC_ABS;
      end
      5'd12: begin
        w.mul_sel = MUL_RECIP;
      end
      5'd13: begin
        w.dp_op    = DP_CMD;
        w.jmp      = JMP_AXIS;
        w.jmp_addr = PC_AXIS;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Pick the program for one item
  function automatic logic [PC_W-1:0] entry_addr(input logic restart,
                                                 input logic active,
                                                 input logic [METHOD_W-1:0] method);
    logic [PC_W-1:0] a;
    priority if (restart) begin
      a = PC_RESTART;
    end else if (!active) begin
      a = PC_HOLD;
    end else if (method == METHOD_PASS) begin
      a = PC_PASS;
    end else if (method == METHOD_AVOID) begin
      a = PC_AVOID;
    end else if (method == METHOD_HOVER) begin
      a = PC_HOVER;
    end else begin
      a = PC_HOLD;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

[rtl/fvpi_seq.sv]
// Microcode sequencer: step counter, control store lookup and axis loop.
`timescale 1ns / 1ps
`default_nettype none

module fvpi_seq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [fvpi_pkg::PC_W-1:0] entry,
  input  wire logic                    out_block,
  output fvpi_pkg::ctl_t               ctl,
  output logic                         busy,
  output logic                         done
);
  import fvpi_pkg::*;

  logic            busy_r;
  logic [PC_W-1:0] pc_r;
  logic            axis_r;
  uword_t          w;
  logic            finishing;
  logic            step_ok;

  // Decode current step
  assign w         = ucode_rom(pc_r);
  assign finishing = w.last | ((w.jmp == JMP_AXIS) & axis_r);
  assign step_ok   = ~finishing | ~out_block;

  assign ctl.en      = busy_r & step_ok;
  assign ctl.axis    = axis_r;
  assign ctl.mul_sel = w.mul_sel;
  assign ctl.acc_op  = w.acc_op;
  assign ctl.dp_op   = w.dp_op;

  assign busy = busy_r;
  assign done = busy_r & finishing & ~out_block;

  // Advance, jump or stop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
      axis_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      pc_r   <= entry;
      axis_r <= 1'b0;
    end else if (busy_r && step_ok) begin
      if (finishing) begin
        busy_r <= 1'b0;
      end else if (w.jmp == JMP_AXIS) begin
        pc_r   <= w.jmp_addr;
        axis_r <= 1'b1;
      end else begin
        pc_r <= pc_r + PC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/fvpi_dp.sv]
// Datapath: shared multiplier, accumulator, error sums and command registers.
`timescale 1ns / 1ps
`default_nettype none

module fvpi_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                ld,
  input  wire fvpi_pkg::in_item_t  item_i,
  input  wire fvpi_pkg::cfg_regs_t cfg_i,
  input  wire fvpi_pkg::ctl_t      ctl_i,
  output fvpi_pkg::out_item_t      cmd_nxt
);
  import fvpi_pkg::*;

  localparam logic signed [37:0]      ALPHA_S   = 38'(ALPHA_Q8);
  localparam logic signed [37:0]      TRUNC_ADJ = 38'((1 << 20) - 1);
  localparam logic signed [ACC_W-1:0] NORM_LIM  = ACC_W'(NORM_ONE);
  localparam logic signed [ACC_W-1:0] SAT_P     = ACC_W'(LIMIT_P);
  localparam logic [CMD_W-1:0]        SAT_MAG   = CMD_W'(SAT_LIMIT);

  in_item_t                 item_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     neg_r;
  logic signed [ERR_W-1:0]  err_x_r, err_y_r, err_x_nxt, err_y_nxt;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r, sum_x_nxt, sum_y_nxt;
  logic signed [CMD_W-1:0]  roll_r, pitch_r, roll_nxt, pitch_nxt;

  logic signed [ERR_W-1:0]   err_sel;
  logic signed [SUM_W-1:0]   sum_sel;
  logic [GAIN_W-1:0]         pg_sel, ig_sel;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_full;
  logic signed [ACC_W-1:0]   prod_lo;
  logic                      big;
  logic signed [ERR_W-1:0]   tx, ty;
  logic [CMD_W-1:0]          quo, mag;
  logic                      sat;

  // Truncated avoidance target: (alpha*ref + vel*2^20) / 2^20 toward zero
  function automatic logic signed [ERR_W-1:0] avoid_tgt(input logic signed [VEL_W-1:0] ref_v,
                                                        input logic signed [VEL_W-1:0] vel_v);
    logic signed [37:0] q, qa;
    q  = 38'(ref_v) * ALPHA_S + (38'(vel_v) <<< 20);
    qa = q + ((q < 0) ? TRUNC_ADJ : 38'sd0);
    return qa[37:20];
  endfunction

  // Add an error to a sum, clamp at the 32-bit limits
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [ERR_W-1:0] e);
    logic signed [SUM_W:0] t;
    t = (SUM_W+1)'(s) + (SUM_W+1)'(e);
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

  // Operand selection for the active axis
  assign err_sel = ctl_i.axis ? err_y_r : err_x_r;
  assign sum_sel = ctl_i.axis ? sum_y_r : sum_x_r;
  assign pg_sel  = ctl_i.axis ? cfg_i.pitch_p_gain : cfg_i.roll_p_gain;
  assign ig_sel  = ctl_i.axis ? cfg_i.pitch_i_gain : cfg_i.roll_i_gain;

  always_comb begin
    unique case (ctl_i.mul_sel)
      MUL_SQ_ROLL: begin
        mul_a = MUL_A_W'(item_r.avoid_roll);
        mul_b = MUL_B_W'(item_r.avoid_roll);
      end
      MUL_SQ_PITCH: begin
        mul_a = MUL_A_W'(item_r.avoid_pitch);
        mul_b = MUL_B_W'(item_r.avoid_pitch);
      end
      MUL_P_ERR: begin
        mul_a = MUL_A_W'(err_sel);
        mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, pg_sel});
      end
      MUL_I_SUM: begin
        mul_a = MUL_A_W'(sum_sel);
        mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, ig_sel});
      end
      MUL_RECIP: begin
        mul_a = MUL_A_W'(DIV_M);
        mul_b = $signed({{(MUL_B_W-DIV_N_W){1'b0}}, acc_r[DIV_N_W-1:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;
  assign prod_lo   = prod_r[ACC_W-1:0];

  // Accumulator
  always_comb begin
    unique case (ctl_i.acc_op)
      ACC_LOAD: acc_nxt = prod_lo;
      ACC_ADD:  acc_nxt = acc_r + prod_lo;
      ACC_ABS:  acc_nxt = acc_r[ACC_W-1] ? -acc_r : acc_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  // Velocity targets
  assign big = acc_r > NORM_LIM;

  always_comb begin
    if (cfg_i.method == METHOD_HOVER) begin
      tx = ERR_W'(cfg_i.target_vx);
      ty = ERR_W'(cfg_i.target_vy);
    end else if (big) begin
      tx = avoid_tgt(item_r.avoid_roll, item_r.vel_x);
      ty = avoid_tgt(item_r.avoid_pitch, item_r.vel_y);
    end else begin
      tx = '0;
      ty = '0;
    end
  end

  // Quotient by reciprocal, clamp on the magnitude
  assign quo = prod_r[DIV_SHIFT +: CMD_W];
  assign sat = acc_r >= SAT_P;
  assign mag = sat ? SAT_MAG : quo;

  // Architectural next state
  always_comb begin
    err_x_nxt = err_x_r;
    err_y_nxt = err_y_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    roll_nxt  = roll_r;
    pitch_nxt = pitch_r;
    if (ctl_i.en) begin
      unique case (ctl_i.dp_op)
        DP_CLEAR: begin
          sum_x_nxt = '0;
          sum_y_nxt = '0;
          roll_nxt  = '0;
          pitch_nxt = '0;
        end
        DP_PASS: begin
          roll_nxt  = item_r.avoid_roll;
          pitch_nxt = item_r.avoid_pitch;
        end
        DP_ERR: begin
          if (item_r.tracked_count != '0) begin
            err_x_nxt = tx - ERR_W'(item_r.vel_x);
            err_y_nxt = ty - ERR_W'(item_r.vel_y);
          end
        end
        DP_SUM: begin
          sum_x_nxt = sat_add(sum_x_r, err_x_r);
          sum_y_nxt = sat_add(sum_y_r, err_y_r);
        end
        DP_CMD: begin
          if (ctl_i.axis) begin
            pitch_nxt = neg_r ? $signed(mag) : -$signed(mag);
          end else begin
            roll_nxt = neg_r ? -$signed(mag) : $signed(mag);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cmd_nxt.roll_cmd  = roll_nxt;
  assign cmd_nxt.pitch_cmd = pitch_nxt;

  // Item and work registers
  always_ff @(posedge clk) begin
    if (ld) begin
      item_r <= item_i;
    end
    if (ctl_i.en && ctl_i.mul_sel != MUL_NONE) begin
      prod_r <= prod_full;
    end
    if (ctl_i.en) begin
      acc_r <= acc_nxt;
    end
    if (ctl_i.en && ctl_i.acc_op == ACC_ABS) begin
      neg_r <= acc_r[ACC_W-1];
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_x_r <= '0;
      err_y_r <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      roll_r  <= '0;
      pitch_r <= '0;
    end else begin
      err_x_r <= err_x_nxt;
      err_y_r <= err_y_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/flow_velocity_pi_controller.sv]
// Top level of the flow velocity PI controller: handshakes, registers, output beat.
//
// Usage:
//   Input beats (in_valid/in_stall/in_data) carry one flow measurement each.
//   Each beat yields exactly one output beat (out_valid/out_stall/out_data)
//   with the current roll and pitch commands.
//   Registers are written through cfg_valid/cfg_ready with cfg_index and
//   cfg_data while no item is in flight; cfg_ready is low while busy.
//   An item runs through a microcoded program on one shared multiplier:
//   restart clears the commands, hold keeps them and pass-through copies the
//   avoidance inputs; flow hover runs the error, sum and per-axis PI steps,
//   and avoidance first forms the squared norm of the avoidance vector and
//   then runs the hover steps. The result is registered into the output register in the cycle after the last step.
//   in_stall is high while a program runs. A finished result waits in the
//   output register while the receiver stalls, and the next input beat is
//   still accepted; a second result holds at its last step until the
//   register frees up.
//   Synchronous reset clears sums, errors and commands, loads the register
//   defaults and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module flow_velocity_pi_controller (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire fvpi_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output fvpi_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fvpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fvpi_pkg::CFG_DAT_W-1:0] cfg_data
);
  import fvpi_pkg::*;

  cfg_regs_t       cfg_r;
  logic            out_valid_r;
  out_item_t       out_data_r;
  logic            busy;
  logic            done;
  logic            in_acc;
  logic            out_block;
  logic [PC_W-1:0] entry;
  ctl_t            ctl;
  out_item_t       cmd_nxt;

  assign in_acc    = in_valid & ~busy;
  assign out_block = out_valid_r & out_stall;
  assign entry     = entry_addr(in_data.restart, in_data.mode_active, cfg_r.method);

  assign in_stall  = busy;
  assign cfg_ready = ~busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fvpi_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .entry     (entry),
    .out_block (out_block),
    .ctl       (ctl),
    .busy      (busy),
    .done      (done)
  );

  fvpi_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld      (in_acc),
    .item_i  (in_data),
    .cfg_i   (cfg_r),
    .ctl_i   (ctl),
    .cmd_nxt (cmd_nxt)
  );

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_METHOD:       cfg_r.method       <= cfg_data[METHOD_W-1:0];
        CFG_ROLL_P_GAIN:  cfg_r.roll_p_gain  <= cfg_data;
        CFG_ROLL_I_GAIN:  cfg_r.roll_i_gain  <= cfg_data;
        CFG_PITCH_P_GAIN: cfg_r.pitch_p_gain <= cfg_data;
        CFG_PITCH_I_GAIN: cfg_r.pitch_i_gain <= cfg_data;
        CFG_TARGET_VX:    cfg_r.target_vx    <= $signed(cfg_data);
        CFG_TARGET_VY:    cfg_r.target_vy    <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Output register: load on program end, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/fvpi_chk.sv]
// Port-level checker for the flow velocity PI controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fvpi_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire fvpi_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire fvpi_pkg::out_item_t out_data
);
  import fvpi_pkg::*;

  // An accepted beat starts a program
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("no program started after input beat");

  // A result only appears at the end of a program
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

  // A restart beat yields cleared commands once the output register is not stalled
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.restart) ##1 !(out_valid && out_stall)
    |=> out_valid && out_data.roll_cmd == '0 && out_data.pitch_cmd == '0)
    else $error("restart did not clear commands");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind flow_velocity_pi_controller fvpi_chk u_fvpi_chk (.*);

`default_nettype wire
